// ----- rtl/lru_kv_pkg.sv -----
// Package of the LRU key-value cache: fixed field widths, codes and state types.
// Depends on nothing; the interfaces and the top level refer to it by scoped names.

package lru_kv_pkg;

   localparam int KEY_W   = 32;
   localparam int VALUE_W = 32;
   localparam int CFG_W   = 7;

   localparam logic [CFG_W-1:0]   CFG_RESET  = 7'd64;
   localparam logic [VALUE_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;

   localparam logic CMD_GET = 1'b0;
   localparam logic CMD_PUT = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE,
      ST_FINISH
   } state_type;

   // What the second sweep does to the slot store.
   typedef enum logic [1:0] {
      ACT_NONE,
      ACT_TOUCH,
      ACT_FILL,
      ACT_EVICT
   } action_type;

endpackage

// ----- rtl/lru_kv_ifs.sv -----
// Valid/ready channel interfaces of the LRU key-value cache: request, response, register write.
// Depends on lru_kv_pkg for the field widths.

interface lru_kv_req_if;
   logic                                valid;
   logic                                ready;
   logic                                command;
   logic signed [lru_kv_pkg::KEY_W-1:0]   lookup_key;
   logic signed [lru_kv_pkg::VALUE_W-1:0] store_value;

   modport source (output valid, command, lookup_key, store_value, input ready);
   modport sink   (input valid, command, lookup_key, store_value, output ready);
endinterface

interface lru_kv_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                found;
   logic signed [lru_kv_pkg::VALUE_W-1:0] read_value;
   logic                                evicted;
   logic signed [lru_kv_pkg::KEY_W-1:0]   evicted_key;

   modport source (output valid, found, read_value, evicted, evicted_key, input ready);
   modport sink   (input valid, found, read_value, evicted, evicted_key, output ready);
endinterface

interface lru_kv_csr_if;
   logic                            valid;
   logic                            ready;
   logic [lru_kv_pkg::CFG_W-1:0]    entries_in_use;

   modport source (output valid, entries_in_use, input ready);
   modport sink   (input valid, entries_in_use, output ready);
endinterface

// ----- rtl/lru_key_value_cache.sv -----
// Top level of the LRU key-value cache: control sequencer around one slot RAM.
// Depends on lru_kv_pkg, the channel interfaces in lru_kv_ifs and lru_kv_ram.
//
// Usage. Requests arrive on req_chan: a get (command 0) looks up lookup_key, a put
// (command 1) stores store_value under lookup_key. Each request yields exactly one
// transfer on rsp_chan carrying found, read_value (the value on a get hit, all ones on
// a get miss, zero on a put), evicted and evicted_key (the key pushed out by a put to
// a full cache, otherwise zero). csr_chan writes the capacity entries_in_use; it is
// always ready and is meant to be written only while no request is in flight.
// A value of zero acts as one, values above MAX_ENTRIES act as MAX_ENTRIES.
//
// Timing. One request is handled at a time. Between acceptance and the response
// transfer, one sweep over the filled slots compares keys and finds the oldest entry,
// then a second sweep rewrites the recency ranks (skipped on a get miss). Both
// sweeps are bounded by the single read and single write port of the slot RAM,
// one slot per cycle.
//
// Reset clears the fill count and sets the capacity to 64; the slot RAM is not
// cleared, as the data of an unfilled slot is never used. A finished response waits in an
// output register while the receiver stalls, and the next request is already
// accepted and processed; only its own response waits for that register to drain.

module lru_key_value_cache #(
   parameter int MAX_ENTRIES = 64
) (
   input  logic        clock,
   input  logic        reset,
   lru_kv_req_if.sink  req_chan,
   lru_kv_rsp_if.source rsp_chan,
   lru_kv_csr_if.sink  csr_chan
);

   localparam int SW     = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW     = $clog2(MAX_ENTRIES + 1);
   localparam int LW     = (CW > lru_kv_pkg::CFG_W) ? CW : lru_kv_pkg::CFG_W;
   localparam int KW     = lru_kv_pkg::KEY_W;
   localparam int VW     = lru_kv_pkg::VALUE_W;
   localparam int WORD_W = KW + VW + SW;

   // Slot word layout: {key, value, rank}. Rank 0 is the most recently used.
   lru_kv_pkg::state_type  state_ff, state_in;
   lru_kv_pkg::action_type act_ff, act_in;

   logic [lru_kv_pkg::CFG_W-1:0] cfg_ff, cfg_in;
   logic [CW-1:0] filled_ff, filled_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] limit_ff, limit_in;
   logic          rvalid_ff, rvalid_in;
   logic [SW-1:0] ridx_ff, ridx_in;

   logic          cmd_ff, cmd_in;
   logic [KW-1:0] key_ff, key_in;
   logic [VW-1:0] val_ff, val_in;

   logic          found_ff, found_in;
   logic [SW-1:0] hit_idx_ff, hit_idx_in;
   logic [SW-1:0] hit_rank_ff, hit_rank_in;
   logic [VW-1:0] hit_value_ff, hit_value_in;
   logic [SW-1:0] old_idx_ff, old_idx_in;
   logic [SW-1:0] old_rank_ff, old_rank_in;
   logic [KW-1:0] old_key_ff, old_key_in;
   logic [SW-1:0] tgt_idx_ff, tgt_idx_in;
   logic [SW-1:0] tgt_rank_ff, tgt_rank_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_found_ff, rsp_found_in;
   logic [VW-1:0] rsp_value_ff, rsp_value_in;
   logic          rsp_evicted_ff, rsp_evicted_in;
   logic [KW-1:0] rsp_evkey_ff, rsp_evkey_in;

   logic              ram_we;
   logic [SW-1:0]     ram_waddr;
   logic [WORD_W-1:0] ram_wdata;
   logic [SW-1:0]     ram_raddr;
   logic [WORD_W-1:0] ram_rdata;

   logic [KW-1:0] rd_key;
   logic [VW-1:0] rd_value;
   logic [SW-1:0] rd_rank;
   logic [LW-1:0] cap;
   logic [LW-1:0] cfg_ext;

   assign rd_key   = ram_rdata[WORD_W-1 -: KW];
   assign rd_value = ram_rdata[SW +: VW];
   assign rd_rank  = ram_rdata[SW-1:0];

   // Effective capacity: zero acts as one, anything above the store is clamped.
   assign cfg_ext = LW'(cfg_ff);
   always_comb begin
      if (cfg_ff == '0) begin
         cap = LW'(1);
      end else if (cfg_ext > LW'(MAX_ENTRIES)) begin
         cap = LW'(MAX_ENTRIES);
      end else begin
         cap = cfg_ext;
      end
   end

   lru_kv_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MAX_ENTRIES)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign req_chan.ready       = (state_ff == lru_kv_pkg::ST_IDLE);
   assign csr_chan.ready       = 1'b1;
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.found       = rsp_found_ff;
   assign rsp_chan.read_value  = rsp_value_ff;
   assign rsp_chan.evicted     = rsp_evicted_ff;
   assign rsp_chan.evicted_key = rsp_evkey_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lru_kv_pkg::ST_IDLE;
         cfg_ff       <= lru_kv_pkg::CFG_RESET;
         filled_ff    <= '0;
         rvalid_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cfg_ff       <= cfg_in;
         filled_ff    <= filled_in;
         rvalid_ff    <= rvalid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff         <= act_in;
      idx_ff         <= idx_in;
      limit_ff       <= limit_in;
      ridx_ff        <= ridx_in;
      cmd_ff         <= cmd_in;
      key_ff         <= key_in;
      val_ff         <= val_in;
      found_ff       <= found_in;
      hit_idx_ff     <= hit_idx_in;
      hit_rank_ff    <= hit_rank_in;
      hit_value_ff   <= hit_value_in;
      old_idx_ff     <= old_idx_in;
      old_rank_ff    <= old_rank_in;
      old_key_ff     <= old_key_in;
      tgt_idx_ff     <= tgt_idx_in;
      tgt_rank_ff    <= tgt_rank_in;
      rsp_found_ff   <= rsp_found_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_evicted_ff <= rsp_evicted_in;
      rsp_evkey_ff   <= rsp_evkey_in;
   end

   always_comb begin
      logic [KW-1:0] new_key;
      logic [VW-1:0] new_value;
      logic [SW-1:0] new_rank;

      state_in       = state_ff;
      act_in         = act_ff;
      cfg_in         = cfg_ff;
      filled_in      = filled_ff;
      idx_in         = idx_ff;
      limit_in       = limit_ff;
      rvalid_in      = 1'b0;
      ridx_in        = ridx_ff;
      cmd_in         = cmd_ff;
      key_in         = key_ff;
      val_in         = val_ff;
      found_in       = found_ff;
      hit_idx_in     = hit_idx_ff;
      hit_rank_in    = hit_rank_ff;
      hit_value_in   = hit_value_ff;
      old_idx_in     = old_idx_ff;
      old_rank_in    = old_rank_ff;
      old_key_in     = old_key_ff;
      tgt_idx_in     = tgt_idx_ff;
      tgt_rank_in    = tgt_rank_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_chan.ready;
      rsp_found_in   = rsp_found_ff;
      rsp_value_in   = rsp_value_ff;
      rsp_evicted_in = rsp_evicted_ff;
      rsp_evkey_in   = rsp_evkey_ff;

      ram_we    = 1'b0;
      ram_waddr = ridx_ff;
      ram_raddr = idx_ff[SW-1:0];
      new_key   = rd_key;
      new_value = rd_value;
      new_rank  = rd_rank;

      if (csr_chan.valid) begin
         cfg_in = csr_chan.entries_in_use;
      end

      case (state_ff)
         lru_kv_pkg::ST_IDLE: begin
            if (req_chan.valid) begin
               cmd_in   = req_chan.command;
               key_in   = req_chan.lookup_key;
               val_in   = req_chan.store_value;
               found_in = 1'b0;
               idx_in   = '0;
               state_in = lru_kv_pkg::ST_SCAN;
            end
         end

         lru_kv_pkg::ST_SCAN: begin
            // Issue one read a cycle; the data of slot ridx returns in the next cycle.
            if (idx_ff < filled_ff) begin
               rvalid_in = 1'b1;
               ridx_in   = idx_ff[SW-1:0];
               idx_in    = idx_ff + CW'(1);
            end
            if (rvalid_ff) begin
               // The first matching slot wins, as does the first slot of highest rank.
               if (!found_ff && rd_key == key_ff) begin
                  found_in     = 1'b1;
                  hit_idx_in   = ridx_ff;
                  hit_rank_in  = rd_rank;
                  hit_value_in = rd_value;
               end
               if (ridx_ff == '0 || rd_rank > old_rank_ff) begin
                  old_idx_in  = ridx_ff;
                  old_rank_in = rd_rank;
                  old_key_in  = rd_key;
               end
            end else if (idx_ff == filled_ff) begin
               // Sweep complete: choose what the rank sweep has to do.
               idx_in = '0;
               if (found_ff) begin
                  act_in      = lru_kv_pkg::ACT_TOUCH;
                  tgt_idx_in  = hit_idx_ff;
                  tgt_rank_in = hit_rank_ff;
               end else if (cmd_ff == lru_kv_pkg::CMD_GET) begin
                  act_in = lru_kv_pkg::ACT_NONE;
               end else if (LW'(filled_ff) < cap) begin
                  act_in = lru_kv_pkg::ACT_FILL;
               end else begin
                  act_in      = lru_kv_pkg::ACT_EVICT;
                  tgt_idx_in  = old_idx_ff;
                  tgt_rank_in = old_rank_ff;
               end
               if (!found_ff && cmd_ff == lru_kv_pkg::CMD_PUT && LW'(filled_ff) < cap) begin
                  limit_in = filled_ff + CW'(1);
               end else begin
                  limit_in = filled_ff;
               end
               if (!found_ff && cmd_ff == lru_kv_pkg::CMD_GET) begin
                  state_in = lru_kv_pkg::ST_FINISH;
               end else begin
                  state_in = lru_kv_pkg::ST_UPDATE;
               end
            end
         end

         lru_kv_pkg::ST_UPDATE: begin
            // Read slot i while the modified word of slot i-1 is written back.
            if (idx_ff < limit_ff) begin
               rvalid_in = 1'b1;
               ridx_in   = idx_ff[SW-1:0];
               idx_in    = idx_ff + CW'(1);
            end
            if (rvalid_ff) begin
               ram_we = 1'b1;
               case (act_ff)
                  lru_kv_pkg::ACT_FILL: begin
                     if (CW'(ridx_ff) == filled_ff) begin
                        new_key   = key_ff;
                        new_value = val_ff;
                        new_rank  = '0;
                     end else begin
                        new_rank = rd_rank + SW'(1);
                     end
                  end
                  lru_kv_pkg::ACT_TOUCH, lru_kv_pkg::ACT_EVICT: begin
                     if (ridx_ff == tgt_idx_ff) begin
                        new_rank = '0;
                        if (cmd_ff == lru_kv_pkg::CMD_PUT) begin
                           new_key   = key_ff;
                           new_value = val_ff;
                        end
                     end else if (rd_rank < tgt_rank_ff) begin
                        new_rank = rd_rank + SW'(1);
                     end
                  end
                  default: begin
                     ram_we = 1'b0;
                  end
               endcase
            end else if (idx_ff == limit_ff) begin
               if (act_ff == lru_kv_pkg::ACT_FILL) begin
                  filled_in = filled_ff + CW'(1);
               end
               state_in = lru_kv_pkg::ST_FINISH;
            end
         end

         lru_kv_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_found_in   = found_ff;
               rsp_evicted_in = (act_ff == lru_kv_pkg::ACT_EVICT);
               rsp_evkey_in   = (act_ff == lru_kv_pkg::ACT_EVICT) ? old_key_ff : '0;
               if (cmd_ff == lru_kv_pkg::CMD_PUT) begin
                  rsp_value_in = '0;
               end else if (found_ff) begin
                  rsp_value_in = hit_value_ff;
               end else begin
                  rsp_value_in = lru_kv_pkg::MISS_VALUE;
               end
               state_in = lru_kv_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = lru_kv_pkg::ST_IDLE;
         end
      endcase

      ram_wdata = {new_key, new_value, new_rank};
   end

endmodule

// ----- rtl/lru_kv_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, read data registered.
// Depends on nothing.

module lru_kv_ram #(
   parameter int  WIDTH  = 32,
   parameter int  DEPTH  = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
